// ----- design/trc_pkg.sv -----
`timescale 1ns / 1ps
package trc_pkg;

  localparam int unsigned MULT_W = 32;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned SUM_W  = 64;

  // Bus widths: fields packed from the lowest bit up, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 136;
  localparam int unsigned M_TDATA_W = 72;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned SHIFT_W = $clog2(MULT_W);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One element pair after classification by the front end.
  typedef struct packed {
    logic signed [MULT_W-1:0] mult1;
    logic signed [MULT_W-1:0] mult2;
    logic signed [ELEM_W-1:0] elem1;
    logic signed [ELEM_W-1:0] elem2;
    logic                     rev;
    logic                     start;
    logic                     skip_reduce;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [MULT_W-1:0] mag1;
    logic [MULT_W-1:0] mag2;
  } gcd_req_t;

  typedef struct packed {
    logic              done;
    logic [MULT_W-1:0] quo1;
    logic [MULT_W-1:0] quo2;
  } gcd_rsp_t;

endpackage

// ----- design/trc_front.sv -----
`timescale 1ns / 1ps
module trc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [trc_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  output logic                           q_valid_o,
  output trc_pkg::item_t                 q_item_o,
  input  logic                           q_pop_i
);

  localparam int unsigned MW = trc_pkg::MULT_W;
  localparam int unsigned EW = trc_pkg::ELEM_W;

  trc_pkg::item_t               mem_q [trc_pkg::QUEUE_DEPTH];
  trc_pkg::item_t               item_in;
  logic [trc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [trc_pkg::QCNT_W-1:0]   cnt_q;
  logic                         push;

  // Unpack the bus and tag the pair: a row start with a zero multiplier
  // bypasses the reduction.
  always_comb begin
    item_in.mult1       = $signed(s_axis_tdata_i[MW-1:0]);
    item_in.mult2       = $signed(s_axis_tdata_i[2*MW-1:MW]);
    item_in.elem1       = $signed(s_axis_tdata_i[2*MW+EW-1:2*MW]);
    item_in.elem2       = $signed(s_axis_tdata_i[2*MW+2*EW-1:2*MW+EW]);
    item_in.rev         = s_axis_tdata_i[2*MW+2*EW] & s_axis_tdata_i[2*MW+2*EW+1];
    item_in.start       = s_axis_tuser_i;
    item_in.skip_reduce = (item_in.mult1 == '0) || (item_in.mult2 == '0);
    item_in.last        = s_axis_tlast_i;
  end

  assign s_axis_tready_o = (cnt_q != trc_pkg::QCNT_W'(trc_pkg::QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign q_valid_o       = (cnt_q != '0);
  assign q_item_o        = mem_q[rd_ptr_q];

  function automatic logic [trc_pkg::QPTR_W-1:0] next_ptr(
    input logic [trc_pkg::QPTR_W-1:0] p
  );
    if (p == trc_pkg::QPTR_W'(trc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (q_pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ----- design/trc_gcd.sv -----
`timescale 1ns / 1ps
module trc_gcd (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trc_pkg::gcd_req_t   req_i,
  output trc_pkg::gcd_rsp_t   rsp_o
);

  localparam int unsigned MW = trc_pkg::MULT_W;

  typedef enum logic [1:0] {
    G_IDLE,
    G_REDUCE,
    G_DIVIDE
  } gstate_e;

  gstate_e                      state_q, state_d;
  logic [MW-1:0]                p_q, p_d, q_q, q_d, g_q, g_d;
  logic [trc_pkg::SHIFT_W-1:0]  k_q, k_d, cnt_q, cnt_d;
  logic [MW-1:0]                n1_q, n1_d, n2_q, n2_d;
  logic [MW-1:0]                r1_q, r1_d, r2_q, r2_d;
  logic                         done_q, done_d;
  logic [MW:0]                  t1, t2;
  logic                         ge1, ge2;

  // One restoring division step for each dividend against the shared divisor.
  always_comb begin
    t1  = {r1_q, n1_q[MW-1]};
    t2  = {r2_q, n2_q[MW-1]};
    ge1 = (t1 >= {1'b0, g_q});
    ge2 = (t2 >= {1'b0, g_q});
  end

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    q_d     = q_q;
    g_d     = g_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    n1_d    = n1_q;
    n2_d    = n2_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    done_d  = 1'b0;
    case (state_q)
      G_IDLE: begin
        if (req_i.start) begin
          p_d     = req_i.mag1;
          q_d     = req_i.mag2;
          n1_d    = req_i.mag1;
          n2_d    = req_i.mag2;
          k_d     = '0;
          state_d = G_REDUCE;
        end
      end
      G_REDUCE: begin
        // Binary form of Euclid's method: one shift or one subtract a step.
        if (p_q == q_q) begin
          g_d     = p_q << k_q;
          r1_d    = '0;
          r2_d    = '0;
          cnt_d   = '0;
          state_d = G_DIVIDE;
        end else if (!p_q[0] && !q_q[0]) begin
          p_d = p_q >> 1;
          q_d = q_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!p_q[0]) begin
          p_d = p_q >> 1;
        end else if (!q_q[0]) begin
          q_d = q_q >> 1;
        end else if (p_q > q_q) begin
          p_d = p_q - q_q;
        end else begin
          q_d = q_q - p_q;
        end
      end
      G_DIVIDE: begin
        r1_d  = ge1 ? MW'(t1 - {1'b0, g_q}) : t1[MW-1:0];
        r2_d  = ge2 ? MW'(t2 - {1'b0, g_q}) : t2[MW-1:0];
        n1_d  = {n1_q[MW-2:0], ge1};
        n2_d  = {n2_q[MW-2:0], ge2};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == trc_pkg::SHIFT_W'(MW - 1)) begin
          done_d  = 1'b1;
          state_d = G_IDLE;
        end
      end
      default: begin
        state_d = G_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    q_q  <= q_d;
    g_q  <= g_d;
    n1_q <= n1_d;
    n2_q <= n2_d;
    r1_q <= r1_d;
    r2_q <= r2_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo1 = n1_q;
  assign rsp_o.quo2 = n2_q;

endmodule

// ----- design/trc_back.sv -----
`timescale 1ns / 1ps
module trc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  trc_pkg::item_t                 q_item_i,
  output logic                           q_pop_o,
  output trc_pkg::gcd_req_t              gcd_req_o,
  input  trc_pkg::gcd_rsp_t              gcd_rsp_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [trc_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  localparam int unsigned MW = trc_pkg::MULT_W;
  localparam int unsigned EW = trc_pkg::ELEM_W;
  localparam int unsigned SW = trc_pkg::SUM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_MUL,
    ST_SUM
  } state_e;

  state_e                state_q, state_d;
  logic signed [MW-1:0]  m1r_q, m1r_d, m2r_q, m2r_d;
  logic                  rev_q, rev_d;
  logic                  neg1_q, neg1_d, neg2_q, neg2_d;
  logic signed [EW-1:0]  a_q, a_d, b_q, b_d;
  logic                  last_q, last_d;
  logic signed [SW-1:0]  p1_q, p1_d, p2_q, p2_d;
  logic                  plast_q, plast_d;
  logic                  out_vld_q, out_vld_d;
  logic signed [SW-1:0]  out_elem_q, out_elem_d;
  logic                  out_rev_q, out_rev_d;
  logic                  out_sat_q, out_sat_d;
  logic                  out_last_q, out_last_d;
  logic                  out_load, take;
  logic signed [SW:0]    sum_w;
  logic                  ovf;

  assign out_load = (state_q == ST_SUM) && (!out_vld_q || m_axis_tready_i);
  assign take     = q_valid_i && ((state_q == ST_IDLE) || out_load);
  assign q_pop_o  = take;

  // At most one bound can be crossed; the top two bits of the wide sum tell which.
  assign sum_w = {p1_q[SW-1], p1_q} + {p2_q[SW-1], p2_q};
  assign ovf   = sum_w[SW] ^ sum_w[SW-1];

  always_comb begin
    state_d    = state_q;
    m1r_d      = m1r_q;
    m2r_d      = m2r_q;
    rev_d      = rev_q;
    neg1_d     = neg1_q;
    neg2_d     = neg2_q;
    a_d        = a_q;
    b_d        = b_q;
    last_d     = last_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    plast_d    = plast_q;
    out_vld_d  = out_vld_q;
    out_elem_d = out_elem_q;
    out_rev_d  = out_rev_q;
    out_sat_d  = out_sat_q;
    out_last_d = out_last_q;

    gcd_req_o.start = 1'b0;
    gcd_req_o.mag1  = q_item_i.mult1[MW-1] ? MW'($unsigned(-q_item_i.mult1))
                                           : MW'($unsigned(q_item_i.mult1));
    gcd_req_o.mag2  = q_item_i.mult2[MW-1] ? MW'($unsigned(-q_item_i.mult2))
                                           : MW'($unsigned(q_item_i.mult2));

    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
      end
      ST_GCD: begin
        if (gcd_rsp_i.done) begin
          m1r_d   = neg1_q ? $signed(-gcd_rsp_i.quo1) : $signed(gcd_rsp_i.quo1);
          m2r_d   = neg2_q ? $signed(-gcd_rsp_i.quo2) : $signed(gcd_rsp_i.quo2);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        p1_d    = m1r_q * a_q;
        p2_d    = m2r_q * b_q;
        plast_d = last_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (out_load) begin
          out_vld_d  = 1'b1;
          out_elem_d = ovf ? (sum_w[SW] ? trc_pkg::SUM_MIN : trc_pkg::SUM_MAX)
                           : sum_w[SW-1:0];
          out_sat_d  = ovf;
          out_rev_d  = rev_q;
          out_last_d = plast_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A new pair enters while the previous sum goes to the output register.
    if (take) begin
      a_d     = q_item_i.elem1;
      b_d     = q_item_i.elem2;
      last_d  = q_item_i.last;
      state_d = ST_MUL;
      if (q_item_i.start) begin
        rev_d = q_item_i.rev;
        if (q_item_i.skip_reduce) begin
          m1r_d = q_item_i.mult1;
          m2r_d = q_item_i.mult2;
        end else begin
          neg1_d          = q_item_i.mult1[MW-1];
          neg2_d          = q_item_i.mult2[MW-1];
          gcd_req_o.start = 1'b1;
          state_d         = ST_GCD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m1r_q     <= '0;
      m2r_q     <= '0;
      rev_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m1r_q     <= m1r_d;
      m2r_q     <= m2r_d;
      rev_q     <= rev_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q     <= neg1_d;
    neg2_q     <= neg2_d;
    a_q        <= a_d;
    b_q        <= b_d;
    last_q     <= last_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    plast_q    <= plast_d;
    out_elem_q <= out_elem_d;
    out_rev_q  <= out_rev_d;
    out_sat_q  <= out_sat_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(trc_pkg::M_TDATA_W - SW - 1){1'b0}}, out_rev_q, out_elem_q};
  assign m_axis_tuser_o  = out_sat_q;
  assign m_axis_tlast_o  = out_last_q;

  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (state_q == ST_IDLE || state_q == ST_SUM))
    else $error("pair taken while the back end was busy");

  a_done_only_in_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_rsp_i.done |-> state_q == ST_GCD)
    else $error("reduction finished with no row start waiting");

  a_mul_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> state_q == ST_SUM)
    else $error("products not followed by the sum step");

  a_sat_is_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_sat_q) |->
      (out_elem_q == trc_pkg::SUM_MAX || out_elem_q == trc_pkg::SUM_MIN))
    else $error("saturated result is not a range bound");

endmodule

// ----- design/tableau_row_combine_gcd_top.sv -----
`timescale 1ns / 1ps
// Combines two tableau rows element by element as m1*a + m2*b, saturated to
// signed 64 bits. On a row-start transfer the two multipliers are divided by
// the greatest common divisor of their magnitudes (skipped if either is zero),
// and the AND of the reversibility flags is kept for the row. A pair within a
// row goes through the back end as a multiply step in the two 32x32
// multipliers, then a 65-bit add and clamp step that waits for a free output
// register and is overlapped with taking the next pair from the two-entry
// input queue. A row start with both multipliers nonzero adds the iterative
// reduction unit: binary Euclid steps (one shift or subtract per cycle), then
// restoring division, one quotient bit per cycle for both multipliers at once.
module tableau_row_combine_gcd_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] first_multiplier, [63:32] second_multiplier, [95:64] first_element,
  // [127:96] second_element, [128] first_reversible, [129] second_reversible
  input  logic [trc_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] row_start
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [63:0] combined_element, [64] result_reversible
  output logic [trc_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // [0] saturated
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  logic               q_valid, q_pop;
  trc_pkg::item_t     q_item;
  trc_pkg::gcd_req_t  gcd_req;
  trc_pkg::gcd_rsp_t  gcd_rsp;

  trc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  trc_gcd u_gcd (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (gcd_req),
    .rsp_o (gcd_rsp)
  );

  trc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .gcd_req_o      (gcd_req),
    .gcd_rsp_i      (gcd_rsp),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule
